>>> design/cartesian_to_spherical_defines.svh
// ---------------------------------------------------------------------------
// cartesian_to_spherical_defines.svh
// Assertion macros used by the cartesian_to_spherical top module.
// ---------------------------------------------------------------------------
`ifndef CARTESIAN_TO_SPHERICAL_DEFINES_SVH
`define CARTESIAN_TO_SPHERICAL_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define C2S_ASSERT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset
`define C2S_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/c2s_pkg.sv
// ---------------------------------------------------------------------------
// c2s_pkg
// Widths, angle table, stage types and the CORDIC step for the converter.
// ---------------------------------------------------------------------------
`default_nettype none

package c2s_pkg;

    // Coordinate and magnitude widths
    localparam int COORD_BITS   = 16;
    localparam int GUARD_BITS   = (COORD_BITS <= 24) ? 8 : (32 - COORD_BITS);
    localparam int MAG_BITS     = COORD_BITS + 1;
    localparam int SUM_BITS     = 2 * COORD_BITS;
    localparam int R_BITS       = COORD_BITS;
    localparam int RXY_BITS     = COORD_BITS + GUARD_BITS;
    localparam int RXY_RAD_BITS = 2 * RXY_BITS;
    localparam int SQ_STEPS     = RXY_BITS;

    // CORDIC datapath
    localparam int CORDIC_STEPS = 18;
    localparam int CW           = COORD_BITS + GUARD_BITS + 4;
    localparam int ANG_BITS     = 20;
    localparam int ACC_BITS     = ANG_BITS + 2;
    localparam int OUT_BITS     = 17;

    localparam logic [ANG_BITS-1:0] ANG_HALF_PI = ANG_BITS'(524288);
    localparam logic [OUT_BITS-1:0] ANG_PI_OUT  = OUT_BITS'(65536);

    // round(atan(2^-i) * 2^20 / pi)
    localparam logic [ANG_BITS-1:0] ATAN_TABLE [32] = '{
        20'd262144, 20'd154753, 20'd81767, 20'd41506, 20'd20834, 20'd10427,
        20'd5215, 20'd2608, 20'd1304, 20'd652, 20'd326, 20'd163, 20'd81,
        20'd41, 20'd20, 20'd10, 20'd5, 20'd3, 20'd1, 20'd1, 20'd0, 20'd0,
        20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0
    };

    // Per-word flags that ride along the whole pipe
    typedef struct packed {
        logic x_neg;
        logic z_neg;
        logic zero_all;
        logic zero_xy;
    } tag_t;

    // Front end result: magnitudes and sums of squares
    typedef struct packed {
        tag_t                tag;
        logic [MAG_BITS-1:0] ax;
        logic [MAG_BITS-1:0] ay;
        logic [MAG_BITS-1:0] az;
        logic [SUM_BITS-1:0] s2;
        logic [SUM_BITS-1:0] s3;
    } front_t;

    // Square root result
    typedef struct packed {
        tag_t                tag;
        logic [MAG_BITS-1:0] ax;
        logic [MAG_BITS-1:0] ay;
        logic [MAG_BITS-1:0] az;
        logic [RXY_BITS-1:0] rxy;
        logic [R_BITS-1:0]   root;
        logic [R_BITS:0]     rem;
    } sq_t;

    // One vectoring lane
    typedef struct packed {
        logic [CW-1:0]       x;
        logic [CW-1:0]       y;
        logic [ACC_BITS-1:0] acc;
    } vec_t;

    // CORDIC result
    typedef struct packed {
        tag_t                tag;
        logic [R_BITS-1:0]   root;
        logic [R_BITS:0]     rem;
        logic [ACC_BITS-1:0] acc_pol;
        logic [ACC_BITS-1:0] acc_az;
    } co_t;

    // One vectoring iteration: rotate toward the x axis
    function automatic vec_t vec_step(vec_t v, int unsigned i);
        logic signed [CW-1:0]       xs;
        logic signed [CW-1:0]       ys;
        logic signed [CW-1:0]       dx;
        logic signed [CW-1:0]       dy;
        logic signed [ACC_BITS-1:0] as;
        logic signed [ACC_BITS-1:0] ang;
        vec_t                       r;
        xs  = $signed(v.x);
        ys  = $signed(v.y);
        as  = $signed(v.acc);
        dx  = ys >>> i;
        dy  = xs >>> i;
        ang = $signed({{(ACC_BITS-ANG_BITS){1'b0}}, ATAN_TABLE[i[4:0]]});
        if (ys > 0)
        begin
            r.x   = xs + dx;
            r.y   = ys - dy;
            r.acc = as + ang;
        end
        else
        begin
            r.x   = xs - dx;
            r.y   = ys + dy;
            r.acc = as - ang;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/cartesian_to_spherical.sv
// ---------------------------------------------------------------------------
// cartesian_to_spherical
// Fully pipelined Cartesian to spherical conversion (radius, polar, azimuth).
// ---------------------------------------------------------------------------
//  Channel  | Handshake          | Ports
//  ---------+--------------------+---------------------------------------------
//  input    | start && !busy     | coord_x, coord_y, coord_z
//  result   | done (1-cycle)     | radius, polar_angle, azimuth_angle
//
//  One word enters per cycle; busy is always low.
//  A word passes the front end, the bit-per-stage square roots, the CORDIC
//  lanes and the output register; the xy length root feeds the polar CORDIC.
//  Reset clears only the valid bits; data registers are not reset.
//  The receiver cannot stall, so the pipe never holds.
// ---------------------------------------------------------------------------
`default_nettype none

`include "cartesian_to_spherical_defines.svh"

module cartesian_to_spherical
    import c2s_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [COORD_BITS-1:0] coord_x,
    input  wire logic [COORD_BITS-1:0] coord_y,
    input  wire logic [COORD_BITS-1:0] coord_z,
    output logic                       done,
    output logic [R_BITS-1:0]          radius,
    output logic [OUT_BITS-1:0]        polar_angle,
    output logic [OUT_BITS-1:0]        azimuth_angle
);

    logic   fr_valid, sq_valid, co_valid;
    front_t fr_data;
    sq_t    sq_data;
    co_t    co_data;

    logic                done_reg;
    logic [R_BITS-1:0]   radius_reg, radius_next;
    logic [OUT_BITS-1:0] polar_reg, polar_next;
    logic [OUT_BITS-1:0] azim_reg, azim_next;
    logic [OUT_BITS-1:0] half_pol, half_az;

    assign busy = 1'b0;

    c2s_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .coord_x   (coord_x),
        .coord_y   (coord_y),
        .coord_z   (coord_z),
        .out_valid (fr_valid),
        .out_data  (fr_data)
    );

    c2s_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_data   (fr_data),
        .out_valid (sq_valid),
        .out_data  (sq_data)
    );

    c2s_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .in_data   (sq_data),
        .out_valid (co_valid),
        .out_data  (co_data)
    );

    // Clamp to 0..pi/2 and reduce pi/2^20 units to pi/2^16 with rounding
    function automatic logic [OUT_BITS-1:0] reduce_angle(logic [ACC_BITS-1:0] acc);
        logic [ANG_BITS-1:0] clamped;
        logic [ANG_BITS:0]   sum;
        if (acc[ACC_BITS-1])
            clamped = '0;
        else if (acc > ACC_BITS'(ANG_HALF_PI))
            clamped = ANG_HALF_PI;
        else
            clamped = acc[ANG_BITS-1:0];
        sum = {1'b0, clamped} + (ANG_BITS+1)'(8);
        return sum[ANG_BITS:4];
    endfunction

    // Output stage: rounding, quadrant fold, special cases
    always_comb
    begin
        half_pol    = reduce_angle(co_data.acc_pol);
        half_az     = reduce_angle(co_data.acc_az);
        radius_next = co_data.root
                    + R_BITS'(co_data.rem > {1'b0, co_data.root});
        polar_next  = co_data.tag.z_neg ? (ANG_PI_OUT - half_pol) : half_pol;
        azim_next   = co_data.tag.x_neg ? (ANG_PI_OUT - half_az) : half_az;
        if (co_data.tag.zero_xy)
            azim_next = '0;
        if (co_data.tag.zero_all)
        begin
            radius_next = '0;
            polar_next  = '0;
            azim_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= co_valid;
    end

    always_ff @(posedge clk)
    begin
        radius_reg <= radius_next;
        polar_reg  <= polar_next;
        azim_reg   <= azim_next;
    end

    assign done          = done_reg;
    assign radius        = radius_reg;
    assign polar_angle   = polar_reg;
    assign azimuth_angle = azim_reg;

    // Checks
    `C2S_ASSERT(a_zero_radius, done && radius == '0, polar_angle == '0 && azimuth_angle == '0, "zero radius with nonzero angle")
    `C2S_ASSERT(a_angle_range, done, polar_angle <= ANG_PI_OUT && azimuth_angle <= ANG_PI_OUT, "angle above pi")
    `C2S_ASSERT_NEXT(a_done_follows, co_valid, done, "result word lost at output stage")
    `C2S_ASSERT_NEXT(a_no_phantom, !co_valid, !done, "result strobe without a word")

endmodule

`default_nettype wire

>>> design/c2s_front.sv
// ---------------------------------------------------------------------------
// c2s_front
// Three stages: magnitudes and signs, squares, sums and zero flags.
// ---------------------------------------------------------------------------
`default_nettype none

module c2s_front
    import c2s_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic [COORD_BITS-1:0] coord_x,
    input  wire logic [COORD_BITS-1:0] coord_y,
    input  wire logic [COORD_BITS-1:0] coord_z,
    output logic                       out_valid,
    output front_t                     out_data
);

    logic                  va_reg, vb_reg, vc_reg;
    logic                  xn_a_reg, zn_a_reg, xn_b_reg, zn_b_reg;
    logic [MAG_BITS-1:0]   ax_a_reg, ay_a_reg, az_a_reg;
    logic [MAG_BITS-1:0]   ax_b_reg, ay_b_reg, az_b_reg;
    logic [SUM_BITS-1:0]   sx_reg, sy_reg, sz_reg;
    logic [MAG_BITS-1:0]   ax_next, ay_next, az_next;
    logic [2*MAG_BITS-1:0] px, py, pz;
    logic [SUM_BITS-1:0]   s2_next, s3_next;
    front_t                data_reg, data_next;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    // Stage A: absolute values
    always_comb
    begin
        ax_next = coord_x[COORD_BITS-1] ? -{coord_x[COORD_BITS-1], coord_x}
                                        : {1'b0, coord_x};
        ay_next = coord_y[COORD_BITS-1] ? -{coord_y[COORD_BITS-1], coord_y}
                                        : {1'b0, coord_y};
        az_next = coord_z[COORD_BITS-1] ? -{coord_z[COORD_BITS-1], coord_z}
                                        : {1'b0, coord_z};
    end

    // Stage B: squares (magnitude squared always fits SUM_BITS)
    always_comb
    begin
        px = ax_a_reg * ax_a_reg;
        py = ay_a_reg * ay_a_reg;
        pz = az_a_reg * az_a_reg;
    end

    // Stage C: sums and special-case flags
    always_comb
    begin
        s2_next                = sx_reg + sy_reg;
        s3_next                = s2_next + sz_reg;
        data_next.tag.x_neg    = xn_b_reg;
        data_next.tag.z_neg    = zn_b_reg;
        data_next.tag.zero_all = (s3_next == '0);
        data_next.tag.zero_xy  = (s2_next == '0);
        data_next.ax           = ax_b_reg;
        data_next.ay           = ay_b_reg;
        data_next.az           = az_b_reg;
        data_next.s2           = s2_next;
        data_next.s3           = s3_next;
    end

    always_ff @(posedge clk)
    begin
        ax_a_reg <= ax_next;
        ay_a_reg <= ay_next;
        az_a_reg <= az_next;
        xn_a_reg <= coord_x[COORD_BITS-1];
        zn_a_reg <= coord_z[COORD_BITS-1];
        sx_reg   <= px[SUM_BITS-1:0];
        sy_reg   <= py[SUM_BITS-1:0];
        sz_reg   <= pz[SUM_BITS-1:0];
        ax_b_reg <= ax_a_reg;
        ay_b_reg <= ay_a_reg;
        az_b_reg <= az_a_reg;
        xn_b_reg <= xn_a_reg;
        zn_b_reg <= zn_a_reg;
        data_reg <= data_next;
    end

    assign out_valid = vc_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

>>> design/c2s_sqrt.sv
// ---------------------------------------------------------------------------
// c2s_sqrt
// Bit-per-stage integer square roots: xy length and full radius in parallel.
// ---------------------------------------------------------------------------
`default_nettype none

module c2s_sqrt
    import c2s_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_valid,
    input  wire front_t in_data,
    output logic        out_valid,
    output sq_t         out_data
);

    typedef struct packed {
        tag_t                    tag;
        logic [MAG_BITS-1:0]     ax;
        logic [MAG_BITS-1:0]     ay;
        logic [MAG_BITS-1:0]     az;
        logic [RXY_RAD_BITS-1:0] rem_xy;
        logic [RXY_BITS-1:0]     q_xy;
        logic [SUM_BITS-1:0]     rem_r;
        logic [R_BITS-1:0]       q_r;
    } sq_stage_t;

    logic      valid_reg [SQ_STEPS];
    sq_stage_t stage_reg [SQ_STEPS];
    sq_stage_t first;

    // Radicands: s2 with guard bits for the xy length, s3 for the radius
    always_comb
    begin
        first.tag    = in_data.tag;
        first.ax     = in_data.ax;
        first.ay     = in_data.ay;
        first.az     = in_data.az;
        first.rem_xy = {in_data.s2, {(2*GUARD_BITS){1'b0}}};
        first.q_xy   = '0;
        first.rem_r  = in_data.s3;
        first.q_r    = '0;
    end

    for (genvar j = 0; j < SQ_STEPS; j++)
    begin : g_step
        localparam int BX = RXY_BITS - 1 - j;
        localparam int BR = (j < R_BITS) ? (R_BITS - 1 - j) : 0;

        sq_stage_t               cur;
        sq_stage_t               stage_next;
        logic                    cur_valid;
        logic [RXY_RAD_BITS-1:0] trial_xy;
        logic [SUM_BITS-1:0]     trial_r;

        if (j == 0)
        begin : g_in
            assign cur       = first;
            assign cur_valid = in_valid;
        end
        else
        begin : g_chain
            assign cur       = stage_reg[j-1];
            assign cur_valid = valid_reg[j-1];
        end

        // Try one root bit: (q + 2^b)^2 - q^2 = q*2^(b+1) + 2^(2b)
        always_comb
        begin
            stage_next = cur;
            trial_xy   = ({{RXY_BITS{1'b0}}, cur.q_xy} << (BX + 1))
                       | (RXY_RAD_BITS'(1) << (2 * BX));
            trial_r    = ({{R_BITS{1'b0}}, cur.q_r} << (BR + 1))
                       | (SUM_BITS'(1) << (2 * BR));
            if (cur.rem_xy >= trial_xy)
            begin
                stage_next.rem_xy = cur.rem_xy - trial_xy;
                stage_next.q_xy   = cur.q_xy | (RXY_BITS'(1) << BX);
            end
            if (j < R_BITS)
            begin
                if (cur.rem_r >= trial_r)
                begin
                    stage_next.rem_r = cur.rem_r - trial_r;
                    stage_next.q_r   = cur.q_r | (R_BITS'(1) << BR);
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[j] <= 1'b0;
            else
                valid_reg[j] <= cur_valid;
        end

        always_ff @(posedge clk)
        begin
            stage_reg[j] <= stage_next;
        end
    end

    // Remainder of the radius root is at most 2*root
    always_comb
    begin
        out_data.tag  = stage_reg[SQ_STEPS-1].tag;
        out_data.ax   = stage_reg[SQ_STEPS-1].ax;
        out_data.ay   = stage_reg[SQ_STEPS-1].ay;
        out_data.az   = stage_reg[SQ_STEPS-1].az;
        out_data.rxy  = stage_reg[SQ_STEPS-1].q_xy;
        out_data.root = stage_reg[SQ_STEPS-1].q_r;
        out_data.rem  = stage_reg[SQ_STEPS-1].rem_r[R_BITS:0];
    end

    assign out_valid = valid_reg[SQ_STEPS-1];

endmodule

`default_nettype wire

>>> design/c2s_cordic.sv
// ---------------------------------------------------------------------------
// c2s_cordic
// Two vectoring CORDIC lanes, one iteration per stage: polar and azimuth.
// ---------------------------------------------------------------------------
`default_nettype none

module c2s_cordic
    import c2s_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    input  wire sq_t  in_data,
    output logic      out_valid,
    output co_t       out_data
);

    typedef struct packed {
        tag_t              tag;
        logic [R_BITS-1:0] root;
        logic [R_BITS:0]   rem;
        vec_t              pol;
        vec_t              azi;
    } co_stage_t;

    logic      valid_reg [CORDIC_STEPS];
    co_stage_t stage_reg [CORDIC_STEPS];
    co_stage_t first;

    // Folded start vectors: (|z|, rxy) and (|x|, |y|) with guard bits
    always_comb
    begin
        first.tag     = in_data.tag;
        first.root    = in_data.root;
        first.rem     = in_data.rem;
        first.pol.x   = CW'({in_data.az, {GUARD_BITS{1'b0}}});
        first.pol.y   = CW'(in_data.rxy);
        first.pol.acc = '0;
        first.azi.x   = CW'({in_data.ax, {GUARD_BITS{1'b0}}});
        first.azi.y   = CW'({in_data.ay, {GUARD_BITS{1'b0}}});
        first.azi.acc = '0;
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_iter
        co_stage_t cur;
        co_stage_t stage_next;
        logic      cur_valid;

        if (i == 0)
        begin : g_in
            assign cur       = first;
            assign cur_valid = in_valid;
        end
        else
        begin : g_chain
            assign cur       = stage_reg[i-1];
            assign cur_valid = valid_reg[i-1];
        end

        always_comb
        begin
            stage_next     = cur;
            stage_next.pol = vec_step(cur.pol, i);
            stage_next.azi = vec_step(cur.azi, i);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i] <= 1'b0;
            else
                valid_reg[i] <= cur_valid;
        end

        always_ff @(posedge clk)
        begin
            stage_reg[i] <= stage_next;
        end
    end

    always_comb
    begin
        out_data.tag     = stage_reg[CORDIC_STEPS-1].tag;
        out_data.root    = stage_reg[CORDIC_STEPS-1].root;
        out_data.rem     = stage_reg[CORDIC_STEPS-1].rem;
        out_data.acc_pol = stage_reg[CORDIC_STEPS-1].pol.acc;
        out_data.acc_az  = stage_reg[CORDIC_STEPS-1].azi.acc;
    end

    assign out_valid = valid_reg[CORDIC_STEPS-1];

endmodule

`default_nettype wire
